@@ rtl/core/lwtp_pkg.sv @@
// Types and constants shared by the layered wall temperature profile block.
package lwtp_pkg;

    localparam int TEMP_W  = 32;
    localparam int FLUX_W  = 48;
    localparam int NUM_W   = 49;   // |dT| << 16 and 2^36 both fit
    localparam int DROP_W  = 41;   // drop clamps at 2^40
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOT_TEMP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_TEMP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOT_COEFF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLD_COEFF = 2'd3;

    localparam logic [CFG_W-1:0] COEFF_RESET = 32'd4096;
    localparam logic [NUM_W-1:0] FILM_NUM    = 49'h10_0000_0000;       // 2^36
    localparam logic [DROP_W-1:0] DROP_CLAMP = 41'h100_0000_0000;      // 2^40
    localparam logic [NUM_W-1:0] FLUX_POS_MAX = 49'h0_7FFF_FFFF_FFFF;
    localparam logic [NUM_W-1:0] FLUX_NEG_MAG = 49'h0_8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] layer_resistance;
        logic               layer_present;
        logic               last_layer;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] surface_temp;
        logic signed [47:0] heat_flux;
        logic [4:0]         point_index;
        logic               status;
        logic               run_end;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_HOT,
        ST_DIV_COLD,
        ST_SUM,
        ST_DIV_FLUX,
        ST_MUL,
        ST_EMIT,
        ST_READ,
        ST_ADD,
        ST_ERR
    } state_t;

endpackage

@@ rtl/core/lwtp_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module lwtp_div
    import lwtp_pkg::*;
#(
    parameter int DW = 38
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DW-1:0]    den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DW-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      shifted;
    logic             qbit;

    always_comb
    begin
        shifted = {rem_reg, num_reg[NUM_W-1]};
        qbit = (shifted >= {1'b0, den_reg});
        if (qbit)
        begin
            rem_next = DW'(shifted - {1'b0, den_reg});
        end
        else
        begin
            rem_next = shifted[DW-1:0];
        end
        num_next = {num_reg[NUM_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

@@ rtl/core/lwtp_mul.sv @@
// Shift-add multiplier giving floor(a * b / 2^16), clamped to 2^40.
module lwtp_mul
    import lwtp_pkg::*;
#(
    parameter int BW = 38
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [FLUX_W-1:0] a,
    input  logic [BW-1:0]     b,
    output logic              done,
    output logic [DROP_W-1:0] drop
);
    localparam int AW    = FLUX_W + BW;
    localparam int CNT_W = $clog2(BW + 1);

    logic [AW-1:0]    acc_reg;
    logic [AW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [AW-17:0]   scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= AW'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[AW-2:0], 1'b0};
            b_reg <= b_reg >> 1;
        end
    end

    always_comb
    begin
        scaled = acc_reg[AW-1:16];
        if (scaled > (AW-16)'(DROP_CLAMP))
        begin
            drop = DROP_CLAMP;
        end
        else
        begin
            drop = scaled[DROP_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

@@ rtl/core/layered_wall_temp_profile.sv @@
// Top level of the layered wall temperature profile block.
// Layer resistances (Q8.24) arrive one word per accepted input; a layer
// word is taken whenever the block is idle. The word marked last_layer
// starts the solve: two film divides and the flux divide run on one shared
// restoring divider, then every point runs the shared shift-add multiplier.
// Results come out hot surface first, then one per stored layer, each
// carrying the flux; run_end marks the last.
// A wall that held a negative layer gives one result with status set.
// The input is stalled from the last word until the final result is taken.
// Divisor and multiplier b operand width: RW = 37 + clog2(MAX_LAYERS+1).
// A result holds in the output register while out_stall is high.
// Reset clears the sequencer, the layer count, the sum and the error flag,
// and sets the configuration registers to their reset values; layer
// storage is not cleared, only entries written in the current wall are
// ever read. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user must do this only when idle, which the block does not enforce.
module layered_wall_temp_profile
    import lwtp_pkg::*;
#(
    parameter int MAX_LAYERS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int CW = $clog2(MAX_LAYERS + 1);
    localparam int IW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int SW = 32 + CW;
    localparam int RW = SW + 5;

    state_t state_reg, state_next;

    logic signed [31:0] hot_temp_reg, cold_temp_reg;
    logic [31:0]        hot_coeff_reg, cold_coeff_reg;

    logic [31:0]   store_mem [MAX_LAYERS];
    logic [31:0]   rd_data_reg;
    logic [IW-1:0] rd_addr;

    logic [CW-1:0] count_reg;
    logic [SW-1:0] sum_reg;
    logic          bad_reg;
    logic [CW-1:0] k_reg;
    logic [RW-1:0] r_hot_reg, r_total_reg, rc_reg;
    logic [RW-1:0] rc_next;
    logic [FLUX_W-1:0] qmag_reg;
    logic [FLUX_W-1:0] qmag_next;
    logic [FLUX_W-1:0] flux_reg;
    logic          neg_reg;
    out_word_t     out_reg;

    logic          in_acc, out_acc, good_layer, bad_now;
    logic          div_start, div_done, mul_start, mul_done;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [RW-1:0]    div_den;
    logic [DROP_W-1:0] drop;
    logic signed [32:0] diff;
    logic [32:0]        diff_mag;
    logic [NUM_W-1:0]   qmag_clamped;
    logic signed [42:0] t_wide;
    logic signed [31:0] t_sat;
    logic [31:0]        k_wide;

    assign in_acc     = in_valid && !in_stall;
    assign out_acc    = out_valid && !out_stall;
    assign good_layer = in_data.layer_present && !in_data.layer_resistance[31];
    assign bad_now    = bad_reg || (in_data.layer_present && in_data.layer_resistance[31]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_data.last_layer)
                begin
                    state_next = bad_now ? ST_ERR : ST_DIV_HOT;
                end
            end
            ST_DIV_HOT:  if (div_done) state_next = ST_DIV_COLD;
            ST_DIV_COLD: if (div_done) state_next = ST_SUM;
            ST_SUM:      state_next = ST_DIV_FLUX;
            ST_DIV_FLUX: if (div_done) state_next = ST_MUL;
            ST_MUL:      if (mul_done) state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    state_next = (k_reg == count_reg) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ:     state_next = ST_ADD;
            ST_ADD:      state_next = ST_MUL;
            ST_ERR:      if (out_acc) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_EMIT) || (state_reg == ST_ERR);
        div_start = (state_next != state_reg) &&
                    ((state_next == ST_DIV_HOT) || (state_next == ST_DIV_COLD) ||
                     (state_next == ST_DIV_FLUX));
        mul_start = (state_next == ST_MUL) && (state_reg != ST_MUL);
        diff      = 33'(hot_temp_reg) - 33'(cold_temp_reg);
        diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
        case (state_next)
            ST_DIV_HOT:
            begin
                div_num = FILM_NUM;
                div_den = (hot_coeff_reg == '0) ? RW'(1) : RW'(hot_coeff_reg);
            end
            ST_DIV_COLD:
            begin
                div_num = FILM_NUM;
                div_den = (cold_coeff_reg == '0) ? RW'(1) : RW'(cold_coeff_reg);
            end
            default:
            begin
                // both films plus the layer sum
                div_num = {diff_mag, 16'd0};
                div_den = r_total_reg + RW'(sum_reg);
            end
        endcase
    end

    always_comb
    begin
        if (neg_reg)
        begin
            qmag_clamped = (div_quo > FLUX_NEG_MAG) ? FLUX_NEG_MAG : div_quo;
        end
        else
        begin
            qmag_clamped = (div_quo > FLUX_POS_MAX) ? FLUX_POS_MAX : div_quo;
        end
        // hand the multiplier the operands as they are being registered
        qmag_next = (state_reg == ST_DIV_FLUX) ? qmag_clamped[FLUX_W-1:0] : qmag_reg;
        rc_next   = (state_reg == ST_ADD) ? rc_reg + RW'(rd_data_reg) : rc_reg;
        t_wide = neg_reg ? 43'(hot_temp_reg) + 43'(drop) : 43'(hot_temp_reg) - 43'(drop);
        if (t_wide > 43'sd2147483647)
        begin
            t_sat = 32'sh7FFF_FFFF;
        end
        else if (t_wide < -43'sd2147483648)
        begin
            t_sat = 32'sh8000_0000;
        end
        else
        begin
            t_sat = t_wide[31:0];
        end
        k_wide  = 32'(k_reg);
        rd_addr = IW'(k_reg - 1'b1);
    end

    lwtp_div #(.DW(RW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    lwtp_mul #(.BW(RW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (qmag_next),
        .b     (rc_next),
        .done  (mul_done),
        .drop  (drop)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hot_temp_reg   <= '0;
            cold_temp_reg  <= '0;
            hot_coeff_reg  <= COEFF_RESET;
            cold_coeff_reg <= COEFF_RESET;
            count_reg      <= '0;
            sum_reg        <= '0;
            bad_reg        <= 1'b0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HOT_TEMP:   hot_temp_reg   <= cfg_data;
                    CFG_COLD_TEMP:  cold_temp_reg  <= cfg_data;
                    CFG_HOT_COEFF:  hot_coeff_reg  <= cfg_data;
                    CFG_COLD_COEFF: cold_coeff_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (in_acc)
            begin
                if (in_data.layer_present && in_data.layer_resistance[31])
                begin
                    bad_reg <= 1'b1;
                end
                else if (good_layer && (count_reg < CW'(MAX_LAYERS)))
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg + SW'(in_data.layer_resistance);
                end
                k_reg <= '0;
            end
            if (out_acc)
            begin
                if (out_reg.run_end)
                begin
                    // wall done: drop the stored layers
                    count_reg <= '0;
                    sum_reg   <= '0;
                    bad_reg   <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
        end
    end

    // layer store and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc && good_layer && (count_reg < CW'(MAX_LAYERS)))
        begin
            store_mem[IW'(count_reg)] <= in_data.layer_resistance;
        end
        rd_data_reg <= store_mem[rd_addr];

        if (state_reg == ST_IDLE)
        begin
            neg_reg <= diff[32];
            out_reg <= '{surface_temp: '0, heat_flux: '0, point_index: '0,
                         status: 1'b1, run_end: 1'b1};
        end
        if ((state_reg == ST_DIV_HOT) && div_done)
        begin
            r_hot_reg <= div_quo[RW-1:0];
            rc_reg    <= div_quo[RW-1:0];
        end
        if ((state_reg == ST_DIV_COLD) && div_done)
        begin
            r_total_reg <= r_hot_reg + div_quo[RW-1:0];
        end
        if ((state_reg == ST_DIV_FLUX) && div_done)
        begin
            qmag_reg <= qmag_clamped[FLUX_W-1:0];
            flux_reg <= neg_reg ? FLUX_W'(-qmag_clamped) : qmag_clamped[FLUX_W-1:0];
        end
        if (state_reg == ST_ADD)
        begin
            rc_reg <= rc_next;
        end
        if ((state_reg == ST_MUL) && mul_done)
        begin
            out_reg.surface_temp <= t_sat;
            out_reg.heat_flux    <= flux_reg;
            out_reg.point_index  <= k_wide[4:0];
            out_reg.status       <= 1'b0;
            out_reg.run_end      <= (k_reg == count_reg);
        end
    end

    assign out_data = out_reg;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status) |-> (out_data.run_end && (out_data.heat_flux == '0)))
        else $error("error result not a lone zero result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LAYERS))
        else $error("layer count beyond depth");

    a_gap_after_point: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && !out_data.run_end) |=> !out_valid)
        else $error("next point shown before it was computed");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_DIV_HOT) || (state_reg == ST_DIV_COLD) ||
                      (state_reg == ST_DIV_FLUX)))
        else $error("divider finished outside a divide step");

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input open while a result is pending");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the layered wall temperature profile block.
`timescale 1ns / 1ps
module testbench;
    import lwtp_pkg::*;

    localparam int LAYERS    = 16;
    localparam int WALL_GAP  = 40;
    localparam int HOLD_LEN  = 400;
    localparam int STALL_MAX = 6000;

    typedef struct {
        in_word_t  word;
        bit        typed;
        out_word_t want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_data;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // profile predictor state
    logic [31:0] hot_temp, cold_temp, hot_coeff, cold_coeff;
    logic [31:0] wall_layers [LAYERS];
    int unsigned wall_count;
    logic [63:0] wall_sum;
    bit          wall_bad;

    out_word_t   profile_q [$];
    stim_row_t   directed [$];
    int          errors;
    bit          quiet;
    bit          hold_req;
    int          hold_left;
    int          idle_run;
    int          items;

    layered_wall_temp_profile dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // Solve one wall word; returns the number of points queued.
    function automatic int solve_profile(input in_word_t w);
        logic [63:0]  r_hot, r_total, num, qmag, rc, drop;
        logic [127:0] prod;
        logic [47:0]  flux;
        longint       th, diff, t;
        bit           neg;
        out_word_t    o;
        int           n;
        if (w.layer_present)
        begin
            if (w.layer_resistance < 0)
                wall_bad = 1'b1;
            else if (wall_count < LAYERS)
            begin
                wall_layers[wall_count] = w.layer_resistance;
                wall_count++;
                wall_sum += {32'd0, w.layer_resistance};
            end
        end
        if (!w.last_layer)
            return 0;
        if (wall_bad)
        begin
            o = '0;
            o.status = 1'b1;
            o.run_end = 1'b1;
            profile_q.insert(profile_q.size(), o);
            wall_count = 0;
            wall_sum = '0;
            wall_bad = 1'b0;
            return 1;
        end
        r_hot = 64'h10_0000_0000 / ((hot_coeff == 0) ? 64'd1 : {32'd0, hot_coeff});
        r_total = r_hot + 64'h10_0000_0000 / ((cold_coeff == 0) ? 64'd1 : {32'd0, cold_coeff})
                  + wall_sum;
        th = longint'($signed(hot_temp));
        diff = th - longint'($signed(cold_temp));
        neg = diff < 0;
        num = (neg ? -diff : diff) << 16;
        qmag = num / r_total;
        if (neg)
        begin
            if (qmag > 64'h8000_0000_0000)
                qmag = 64'h8000_0000_0000;
            flux = -qmag[47:0];
        end
        else
        begin
            if (qmag > 64'h7FFF_FFFF_FFFF)
                qmag = 64'h7FFF_FFFF_FFFF;
            flux = qmag[47:0];
        end
        n = wall_count;
        rc = r_hot;
        for (int k = 0; k <= n; k++)
        begin
            if (k > 0)
                rc += {32'd0, wall_layers[k-1]};
            prod = {64'd0, qmag} * {64'd0, rc};
            prod = prod >> 16;
            drop = (prod > 128'h100_0000_0000) ? 64'h100_0000_0000 : prod[63:0];
            t = neg ? th + longint'(drop) : th - longint'(drop);
            if (t > 64'sh7FFF_FFFF)
                t = 64'sh7FFF_FFFF;
            if (t < -64'sh8000_0000)
                t = -64'sh8000_0000;
            o.surface_temp = t[31:0];
            o.heat_flux = flux;
            o.point_index = k[4:0];
            o.status = 1'b0;
            o.run_end = (k == n);
            profile_q.insert(profile_q.size(), o);
        end
        wall_count = 0;
        wall_sum = '0;
        wall_bad = 1'b0;
        return n + 1;
    endfunction

    // Result check
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (profile_q.size() == 0)
                report("result word with nothing expected");
            else
            begin
                out_word_t want;
                want = profile_q.pop_front();
                if (out_data.surface_temp !== want.surface_temp)
                    report($sformatf("surface_temp %h, want %h",
                                     out_data.surface_temp, want.surface_temp));
                if (out_data.heat_flux !== want.heat_flux)
                    report($sformatf("heat_flux %h, want %h",
                                     out_data.heat_flux, want.heat_flux));
                if (out_data.point_index !== want.point_index)
                    report($sformatf("point_index %0d, want %0d",
                                     out_data.point_index, want.point_index));
                if (out_data.status !== want.status)
                    report($sformatf("status %b, want %b", out_data.status, want.status));
                if (out_data.run_end !== want.run_end)
                    report($sformatf("run_end %b, want %b", out_data.run_end, want.run_end));
            end
        end
    end

    // Receiver: random stall, quiet stretch, or a long hold-off
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_LEN;
            hold_req = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 19);
    end

    // Watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_run = 0;
        else if (++idle_run >= STALL_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
        int n;
        while (!quiet && $urandom_range(99) < 19)
            @(negedge clk);
        in_data = w;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        n = solve_profile(w);
        if (typed)
        begin
            repeat (n) void'(profile_q.pop_back());
            profile_q.insert(profile_q.size(), want);
        end
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain;
        while (profile_q.size() != 0)
            @(posedge clk);
        repeat (WALL_GAP) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_HOT_TEMP:   hot_temp = val;
            CFG_COLD_TEMP:  cold_temp = val;
            CFG_HOT_COEFF:  hot_coeff = val;
            CFG_COLD_COEFF: cold_coeff = val;
            default:        ;
        endcase
    endtask

    task automatic add_row(input logic [31:0] r, input bit p, input bit l,
                           input bit typed, input out_word_t want);
        stim_row_t row;
        row.word.layer_resistance = r;
        row.word.layer_present = p;
        row.word.last_layer = l;
        row.typed = typed;
        row.want = want;
        directed.insert(directed.size(), row);
    endtask

    task automatic random_wall;
        in_word_t w;
        int n;
        n = ($urandom_range(99) < 10) ? $urandom_range(18, 17) : $urandom_range(0, 6);
        for (int k = 0; k <= n; k++)
        begin
            if ($urandom_range(99) < 10)
            begin
                // noise: neither layer nor end of wall
                w.layer_resistance = $urandom;
                w.layer_present = 1'b0;
                w.last_layer = 1'b0;
                send_word(w, 1'b0, '0);
            end
            if (k == n && n == 0)
                w.layer_present = 1'b0;
            else if (k == n)
                break;
            else
                w.layer_present = 1'b1;
            w.layer_resistance = ($urandom_range(99) < 12) ? $urandom
                                                           : $urandom_range(0, 32'h0400_0000);
            w.last_layer = (k == n - 1) || (n == 0);
            send_word(w, 1'b0, '0);
            items++;
        end
    endtask

    initial
    begin
        out_word_t empty_pt, bad_pt;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_HOT_TEMP;
        cfg_data = '0;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        hold_left = 0;
        idle_run = 0;
        items = 0;
        hot_temp = '0;
        cold_temp = '0;
        hot_coeff = COEFF_RESET;
        cold_coeff = COEFF_RESET;
        wall_count = 0;
        wall_sum = '0;
        wall_bad = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed walls on reset settings
        empty_pt = '0;
        empty_pt.run_end = 1'b1;
        bad_pt = '0;
        bad_pt.status = 1'b1;
        bad_pt.run_end = 1'b1;
        add_row(32'h0, 1'b0, 1'b1, 1'b1, empty_pt);           // empty wall
        add_row(32'h8000_0000, 1'b1, 1'b0, 1'b0, '0);         // negative layer
        add_row(32'h0100_0000, 1'b1, 1'b1, 1'b1, bad_pt);
        add_row(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0);         // noise word
        add_row(32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'h0, 1'b1, 1'b0, 1'b0, '0);
        add_row(32'h1, 1'b1, 1'b1, 1'b0, '0);
        for (int k = 1; k <= 17; k++)                         // one past the store depth
            add_row(32'h1, 1'b1, k == 17, 1'b0, '0);
        foreach (directed[i])
            send_word(directed[i].word, directed[i].typed, directed[i].want);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    write_cfg(CFG_HOT_TEMP, 32'h7FFF_FFFF);
                    write_cfg(CFG_COLD_TEMP, 32'h8000_0000);
                    write_cfg(CFG_HOT_COEFF, 32'h0);
                    write_cfg(CFG_COLD_COEFF, 32'h0);
                end
                1:
                begin
                    write_cfg(CFG_HOT_TEMP, 32'h8000_0000);
                    write_cfg(CFG_COLD_TEMP, 32'h7FFF_FFFF);
                    write_cfg(CFG_HOT_COEFF, 32'hFFFF_FFFF);
                    write_cfg(CFG_COLD_COEFF, 32'hFFFF_FFFF);
                    hold_req = 1'b1;
                end
                default:
                begin
                    write_cfg(CFG_HOT_TEMP, ($urandom_range(1)) ? $urandom
                                            : $urandom_range(32'h0100_0000, 32'h0300_0000));
                    write_cfg(CFG_COLD_TEMP, ($urandom_range(1)) ? $urandom
                                             : $urandom_range(32'h0100_0000, 32'h0300_0000));
                    write_cfg(CFG_HOT_COEFF, ($urandom_range(1)) ? $urandom
                                             : $urandom_range(1, 32'h0040_0000));
                    write_cfg(CFG_COLD_COEFF, ($urandom_range(1)) ? $urandom
                                              : $urandom_range(1, 32'h0040_0000));
                end
            endcase
            quiet = (phase == 3);
            while (items < 36 * (phase + 1))
                random_wall();
            // pause sender until every point is out
            drain();
        end
        quiet = 1'b0;

        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
